@@ hw/rtl/xcfp_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared constants and types for the XOR-checked frame parser.
// ----------------------------------------------------------------------------
package xcfp_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned WORD_W    = 16;
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned PHASE_W   = 3;
   localparam int unsigned RSP_DATA_W = 2 * BYTE_W + WORD_W;

   localparam logic [BYTE_W-1:0] HDR_P     = 8'h50;
   localparam logic [BYTE_W-1:0] HDR_D     = 8'h44;
   localparam logic [BYTE_W-1:0] HDR_C     = 8'h43;
   localparam logic [BYTE_W-1:0] SEP_COLON = 8'h3A;

   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_GOT_P   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_GOT_D   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_GOT_C   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_COLON   = 3'd5;
   localparam logic [PHASE_W-1:0] PH_COMMAND = 3'd6;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd7;

   localparam logic [STATUS_W-1:0] ST_NONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_GOOD = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LOST = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] frame_status;
      logic [WORD_W-1:0]   payload_word;
      logic [BYTE_W-1:0]   payload_length;
      logic [BYTE_W-1:0]   command_code;
   } result_type;

endpackage

@@ hw/rtl/xcfp_parser.sv @@
// ----------------------------------------------------------------------------
// xcfp_parser
// Frame parsing state, running XOR and header timer, advanced one item per
// enabled cycle; the result of the item is given combinationally.
// ----------------------------------------------------------------------------
module xcfp_parser
   import xcfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              operation,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [TICK_W-1:0] timeout_ticks,
   output result_type        result
);

   logic [PHASE_W-1:0] phase_ff,   phase_in;
   logic [BYTE_W-1:0]  length_ff,  length_in;
   logic [BYTE_W-1:0]  count_ff,   count_in;
   logic [BYTE_W-1:0]  command_ff, command_in;
   logic [BYTE_W-1:0]  xor_ff,     xor_in;
   logic [WORD_W-1:0]  word_ff,    word_in;
   logic [TICK_W-1:0]  tick_ff,    tick_in;
   logic               timer_on_ff, timer_on_in;
   logic [TICK_W-1:0]  tick_inc;

   assign tick_inc = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      command_in  = command_ff;
      xor_in      = xor_ff;
      word_in     = word_ff;
      tick_in     = tick_ff;
      timer_on_in = timer_on_ff;
      result      = '0;
      if (operation == OP_TICK) begin
         if (timer_on_ff) begin
            tick_in = tick_inc;
            if (tick_inc >= timeout_ticks) begin
               timer_on_in         = 1'b0;
               tick_in             = '0;
               phase_in            = PH_HUNT;
               result.frame_status = ST_LOST;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == HDR_P) begin
                  tick_in     = '0;
                  timer_on_in = 1'b1;
                  xor_in      = rx_byte;
                  phase_in    = PH_GOT_P;
               end
            end
            PH_GOT_P: begin
               if (rx_byte == HDR_D) begin
                  xor_in   = xor_ff ^ rx_byte;
                  phase_in = PH_GOT_D;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_GOT_D: begin
               if (rx_byte == HDR_C) begin
                  xor_in   = xor_ff ^ rx_byte;
                  phase_in = PH_GOT_C;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_GOT_C: begin
               if (rx_byte == HDR_C) begin
                  xor_in   = xor_ff ^ rx_byte;
                  phase_in = PH_LENGTH;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LENGTH: begin
               length_in = rx_byte;
               xor_in    = xor_ff ^ rx_byte;
               phase_in  = PH_COLON;
            end
            PH_COLON: begin
               if (rx_byte == SEP_COLON) begin
                  xor_in   = xor_ff ^ rx_byte;
                  phase_in = PH_COMMAND;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_COMMAND: begin
               command_in = rx_byte;
               xor_in     = xor_ff ^ rx_byte;
               count_in   = '0;
               word_in    = '0;
               phase_in   = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (count_ff == length_ff) begin
                  result.frame_status   = (xor_ff == rx_byte) ? ST_GOOD : ST_BAD;
                  result.command_code   = command_ff;
                  result.payload_length = length_ff;
                  result.payload_word   = word_ff;
                  timer_on_in           = 1'b0;
                  tick_in               = '0;
                  phase_in              = PH_HUNT;
               end else begin
                  xor_in = xor_ff ^ rx_byte;
                  if (count_ff == 8'd0) begin
                     word_in[BYTE_W-1:0] = rx_byte;
                  end else if (count_ff == 8'd1) begin
                     word_in[WORD_W-1:BYTE_W] = rx_byte;
                  end
                  count_in = count_ff + 8'd1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         length_ff   <= '0;
         count_ff    <= '0;
         command_ff  <= '0;
         xor_ff      <= '0;
         word_ff     <= '0;
         tick_ff     <= '0;
         timer_on_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         command_ff  <= command_in;
         xor_ff      <= xor_in;
         word_ff     <= word_in;
         tick_ff     <= tick_in;
         timer_on_ff <= timer_on_in;
      end
   end

endmodule

@@ hw/rtl/xor_checked_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_parser_unit
// Deframer for P D C C <len> ':' <cmd> <payload> <xor> frames with a timeout.
// ----------------------------------------------------------------------------
// Each request on the req_ channel is either a received byte (req_tuser 0)
// or one timer tick (req_tuser 1). Every request yields exactly one response
// on the rsp_ channel: rsp_tuser carries the frame status (none, good frame,
// checksum error, packet lost by timeout), rsp_tdata the command, the declared
// length and the first two payload bytes of a completed frame.
// The csr_ channel writes the timeout in ticks; it is always ready and should
// only be written while no request is in flight.
// A request is captured in an input register, parsed combinationally and the
// response lands in an output register; one request is taken every cycle
// while rsp_tready is high.
// When the receiver stalls, the output register holds its response and the
// input register holds one more request; req_tready drops only when both are
// full. Reset clears the parser to header hunting, stops the timer, empties
// both registers and loads a timeout of 500 ticks.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_unit
   import xcfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   input  logic                  req_tuser,   // [0] operation
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] command_code,
                                              // [15:8] payload_length,
                                              // [31:16] payload_word
   output logic [STATUS_W-1:0]   rsp_tuser,   // [1:0] frame_status
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TICK_W-1:0]     csr_data
);

   logic              in_valid_ff;
   logic              in_op_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   result_type        out_result_ff;
   logic [TICK_W-1:0] timeout_ff;
   logic              advance;
   result_type        step_result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_data;
      end
   end

   xcfp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .operation     (in_op_ff),
      .rx_byte       (in_byte_ff),
      .timeout_ticks (timeout_ff),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.frame_status;
   assign rsp_tdata  = {out_result_ff.payload_word, out_result_ff.payload_length,
                        out_result_ff.command_code};

   a_quiet_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_NONE || rsp_tuser == ST_LOST)
         |-> rsp_tdata == '0)
      else $error("response without a frame carries nonzero data");

   a_fill_out: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("pending request did not reach the output register");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_tready)
      else $error("request channel stalled with an empty output register");

endmodule

@@ dv/xor_checked_frame_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_checked_frame_parser_unit_tb
// Self-checking bench for the XOR-checked frame deframer.
// ----------------------------------------------------------------------------
// Byte and tick requests go in on the req_ stream, and a tracking copy of the
// parser works out the response that each accepted request must produce. A
// checker compares every response with the oldest outstanding expectation.
// Random frames with damage, noise and ticks, first at the reset timeout, then
// after directed frames at others, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module xor_checked_frame_parser_unit_tb;
   import xcfp_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  req_tuser = OP_BYTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [TICK_W-1:0]     csr_data = '0;

   // Tracking copy of the parser state and its timeout register.
   logic [PHASE_W-1:0] hunt_stage = PH_HUNT;
   logic [BYTE_W-1:0]  frame_len = '0;
   logic [BYTE_W-1:0]  bytes_seen = '0;
   logic [BYTE_W-1:0]  frame_cmd = '0;
   logic [BYTE_W-1:0]  frame_xor = '0;
   logic [WORD_W-1:0]  frame_word = '0;
   logic [TICK_W-1:0]  ticks_elapsed = '0;
   logic               timer_armed = 1'b0;
   logic [TICK_W-1:0]  timeout_limit = TIMEOUT_RESET;

   result_type pending_results[$];

   int requests_sent = 0;
   int fail_count = 0;
   int good_seen = 0;
   int bad_seen = 0;
   int lost_seen = 0;
   int settings_used = 0;
   int rsp_hold_cycles = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;

   xor_checked_frame_parser_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void match_header(input logic [BYTE_W-1:0] b,
                                        input logic [BYTE_W-1:0] wanted);
      if (b == wanted) begin
         frame_xor = frame_xor ^ b;
         hunt_stage = hunt_stage + 1'b1;
      end else begin
         hunt_stage = PH_HUNT;
      end
   endfunction

   function automatic result_type parse_event(input logic op, input logic [BYTE_W-1:0] b);
      result_type r;
      r = '0;
      r.frame_status = ST_NONE;
      if (op == OP_TICK) begin
         if (timer_armed) begin
            if (ticks_elapsed != TICK_MAX) ticks_elapsed = ticks_elapsed + 1'b1;
            if (ticks_elapsed >= timeout_limit) begin
               timer_armed = 1'b0;
               ticks_elapsed = '0;
               hunt_stage = PH_HUNT;
               r.frame_status = ST_LOST;
            end
         end
         return r;
      end
      case (hunt_stage)
         PH_HUNT: begin
            if (b == HDR_P) begin
               ticks_elapsed = '0;
               timer_armed = 1'b1;
               frame_xor = b;
               hunt_stage = PH_GOT_P;
            end
         end
         PH_GOT_P: match_header(b, HDR_D);
         PH_GOT_D: match_header(b, HDR_C);
         PH_GOT_C: match_header(b, HDR_C);
         PH_LENGTH: begin
            frame_len = b;
            frame_xor = frame_xor ^ b;
            hunt_stage = PH_COLON;
         end
         PH_COLON: match_header(b, SEP_COLON);
         PH_COMMAND: begin
            frame_cmd = b;
            frame_xor = frame_xor ^ b;
            bytes_seen = '0;
            frame_word = '0;
            hunt_stage = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (bytes_seen == frame_len) begin
               r.frame_status = (frame_xor == b) ? ST_GOOD : ST_BAD;
               r.command_code = frame_cmd;
               r.payload_length = frame_len;
               r.payload_word = frame_word;
               timer_armed = 1'b0;
               ticks_elapsed = '0;
               hunt_stage = PH_HUNT;
            end else begin
               frame_xor = frame_xor ^ b;
               if (bytes_seen == 0) frame_word[7:0] = b;
               else if (bytes_seen == 1) frame_word[15:8] = b;
               bytes_seen = bytes_seen + 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] xor_of(input logic [BYTE_W-1:0] bytes[$]);
      logic [BYTE_W-1:0] acc;
      acc = '0;
      foreach (bytes[i]) acc = acc ^ bytes[i];
      return acc;
   endfunction

   task automatic note_failure(input string what, input result_type want,
                               input result_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $write("[%0t] %s: expected st=%0d cmd=%02h len=%02h word=%04h, ",
                $time, what, want.frame_status, want.command_code, want.payload_length,
                want.payload_word);
         $display("got st=%0d cmd=%02h len=%02h word=%04h",
                  got.frame_status, got.command_code, got.payload_length,
                  got.payload_word);
      end
   endtask

   // The valid is left high after an accept so that a back-to-back request
   // never sees it lowered and raised in the same time step.
   task automatic send_event(input logic op, input logic [BYTE_W-1:0] b);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_results.push_back(parse_event(op, b));
      requests_sent++;
   endtask

   task automatic send_bytes(input logic [BYTE_W-1:0] bytes[$], input int count,
                             input int tick_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < tick_pct)
            send_event(OP_TICK, 8'($urandom_range(0, 255)));
         send_event(OP_BYTE, bytes[i]);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TICK_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      timeout_limit = value;
      settings_used++;
   endtask

   // A well-formed frame with random content, sometimes damaged in the header,
   // the checksum or by being cut short.
   task automatic send_frame(input int tick_pct, input int fixed_len);
      logic [BYTE_W-1:0] frame_bytes[$];
      int len;
      int kind;
      int count;
      if (fixed_len >= 0) len = fixed_len;
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(5, 16);
      else len = $urandom_range(0, 4);
      frame_bytes = '{HDR_P, HDR_D, HDR_C, HDR_C, len[7:0], SEP_COLON,
                      8'($urandom_range(0, 255))};
      for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(xor_of(frame_bytes));
      count = frame_bytes.size();
      kind = $urandom_range(0, 99);
      if (kind < 10) frame_bytes[$urandom_range(1, 5)] = 8'($urandom_range(0, 255));
      else if (kind < 22)
         frame_bytes[count-1] = frame_bytes[count-1] ^ 8'($urandom_range(1, 255));
      else if (kind < 30) count = $urandom_range(1, count - 1);
      send_bytes(frame_bytes, count, tick_pct);
   endtask

   task automatic run_frames(input int item_count, input int tick_pct);
      int start;
      int pick;
      start = requests_sent;
      while (requests_sent - start < item_count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) send_event(OP_BYTE, 8'($urandom_range(0, 255)));
         else if (pick < 18) send_event(OP_TICK, 8'($urandom_range(0, 255)));
         else send_frame(tick_pct, -1);
      end
   endtask

   task automatic test_directed_frames();
      logic [BYTE_W-1:0] bytes[$];
      write_timeout(16'd2);
      send_event(OP_TICK, 8'hFF);
      bytes = '{HDR_P, HDR_D, HDR_C, HDR_C, 8'h00, SEP_COLON, 8'hFF};
      bytes.push_back(xor_of(bytes) ^ 8'h01);
      send_bytes(bytes, bytes.size(), 0);
      bytes = '{HDR_P, HDR_D, HDR_C, HDR_C, 8'h01, SEP_COLON, 8'h00, 8'hFF};
      bytes.push_back(xor_of(bytes));
      send_bytes(bytes, bytes.size(), 0);
      send_event(OP_BYTE, HDR_P);
      send_event(OP_BYTE, HDR_P);
      send_event(OP_TICK, 8'h00);
      send_event(OP_TICK, 8'hFF);
      bytes = '{HDR_P, HDR_D, HDR_C, HDR_C, 8'h80, 8'h3B};
      send_bytes(bytes, bytes.size(), 0);
   endtask

   task automatic test_default_timeout();
      write_timeout(TIMEOUT_RESET);
      run_frames(150, 4);
   endtask

   task automatic test_short_timeouts();
      write_timeout(16'd1);
      run_frames(90, 12);
      write_timeout(16'd0);
      run_frames(90, 12);
      write_timeout(16'($urandom_range(2, 12)));
      run_frames(90, 12);
      write_timeout(16'($urandom_range(13, 40)));
      run_frames(90, 15);
   endtask

   task automatic test_longest_frame();
      write_timeout(TICK_MAX);
      send_frame(3, 255);
      run_frames(60, 20);
   endtask

   task automatic test_back_to_back();
      write_timeout(16'd8);
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      run_frames(100, 10);
      wait_idle();
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_receiver_backpressure();
      req_gaps_on = 1'b0;
      rsp_hold_cycles = 60;
      run_frames(40, 0);
      wait_idle();
      req_gaps_on = 1'b1;
   endtask

   initial begin : response_sink
      int stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            while (rsp_hold_cycles > 0) begin
               @(posedge clock);
               rsp_hold_cycles--;
            end
         end else begin
            stall = rsp_stalls_on ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin : response_check
      result_type want;
      result_type got;
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got.frame_status = rsp_tuser;
         got.command_code = rsp_tdata[7:0];
         got.payload_length = rsp_tdata[15:8];
         got.payload_word = rsp_tdata[31:16];
         if (pending_results.size() == 0) begin
            note_failure("response with no request outstanding", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.frame_status !== want.frame_status
                || got.command_code !== want.command_code
                || got.payload_length !== want.payload_length
                || got.payload_word !== want.payload_word)
               note_failure("response mismatch", want, got);
            if (want.frame_status == ST_GOOD) good_seen++;
            else if (want.frame_status == ST_BAD) bad_seen++;
            else if (want.frame_status == ST_LOST) lost_seen++;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_default_timeout();
      test_directed_frames();
      test_short_timeouts();
      test_longest_frame();
      test_back_to_back();
      test_receiver_backpressure();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Sent %0d requests under %0d timeout settings, including a 255-byte payload.",
               requests_sent, settings_used);
      $display("Frames seen: %0d good, %0d checksum errors, %0d lost by timeout.",
               good_seen, bad_seen, lost_seen);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
